// File: src/triangle_primitive_assembly_macros.svh
//------------------------------------------------------------------------------
// Triangle primitive assembly assertion macros
// Shared concurrent assertion forms for the checker of the assembly block.
//------------------------------------------------------------------------------
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLY_MACROS_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLY_MACROS_SVH

// Assertion that is switched off while reset is high.
`define TPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Assertion that is checked during reset as well.
`define TPA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// File: src/tpa_pkg.sv
//------------------------------------------------------------------------------
// Triangle primitive assembly package
// Types, constants and codes shared by the assembly block.
//------------------------------------------------------------------------------
package tpa_pkg;

   localparam int INDEX_BITS = 32;
   localparam int CORNER_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [1:0] {
      MODE_LIST  = 2'd0,
      MODE_STRIP = 2'd1,
      MODE_FAN   = 2'd2
   } tpa_mode_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIMITIVE_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_BASE = 1'd1;

   typedef struct packed {
      logic [INDEX_BITS-1:0] older_index;
      logic [INDEX_BITS-1:0] newer_index;
      logic [INDEX_BITS-1:0] anchor_index;
      logic [1:0]            seen_count;
      logic                  position_parity;
      logic [1:0]            list_slot;
   } tpa_state_type;

   typedef struct packed {
      logic                   emit;
      logic [CORNER_BITS-1:0] corner_a;
      logic [CORNER_BITS-1:0] corner_b;
      logic [CORNER_BITS-1:0] corner_c;
   } tpa_result_type;

endpackage

// File: src/triangle_primitive_assembly.sv
//------------------------------------------------------------------------------
// Triangle primitive assembly
// Latency: a triangle is valid on rsp_ the cycle after its closing request.
// Throughput: one request per cycle unless a held result stalls req_ready; the result register is the only stage.
// Requests that close no triangle leave no result.
// Reset clears the history, the result valid flag and both CSRs to zero.
//------------------------------------------------------------------------------
module triangle_primitive_assembly (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_vertex_index,
   input  logic                              req_first_of_primitive,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_corner_a,
   output logic [31:0]                       rsp_corner_b,
   output logic [31:0]                       rsp_corner_c,
   input  logic                              csr_write_enable,
   input  logic [tpa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tpa_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   tpa_pkg::tpa_state_type  state_ff;
   tpa_pkg::tpa_state_type  state_in;
   tpa_pkg::tpa_result_type result;
   logic [1:0]              mode_ff;
   logic [31:0]             base_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             corner_a_ff;
   logic [31:0]             corner_b_ff;
   logic [31:0]             corner_c_ff;
   logic                    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   tpa_core u_core (
      .state      (state_ff),
      .cur_index  (req_vertex_index[tpa_pkg::INDEX_BITS-1:0]),
      .first      (req_first_of_primitive),
      .mode       (mode_ff),
      .base       (base_ff),
      .next_state (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         base_ff <= 32'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tpa_pkg::CSR_PRIMITIVE_MODE: mode_ff <= csr_write_data[1:0];
            tpa_pkg::CSR_VERTEX_BASE:    base_ff <= csr_write_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= result.emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.emit) begin
         corner_a_ff <= result.corner_a;
         corner_b_ff <= result.corner_b;
         corner_c_ff <= result.corner_c;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_corner_a = corner_a_ff;
   assign rsp_corner_b = corner_b_ff;
   assign rsp_corner_c = corner_c_ff;

endmodule

// File: src/tpa_core.sv
//------------------------------------------------------------------------------
// Triangle primitive assembly core
// Forms the triangle for one index from the tracked history and gives the
// next history.
//------------------------------------------------------------------------------
module tpa_core (
   input  tpa_pkg::tpa_state_type         state,
   input  logic [tpa_pkg::INDEX_BITS-1:0] cur_index,
   input  logic                           first,
   input  logic [1:0]                     mode,
   input  logic [tpa_pkg::CORNER_BITS-1:0] base,
   output tpa_pkg::tpa_state_type         next_state,
   output tpa_pkg::tpa_result_type        result
);

   logic [1:0]                     seen;
   logic                           parity;
   logic [1:0]                     slot;
   logic [tpa_pkg::INDEX_BITS-1:0] anchor;
   logic [tpa_pkg::INDEX_BITS-1:0] pick_a;
   logic [tpa_pkg::INDEX_BITS-1:0] pick_b;
   logic [tpa_pkg::INDEX_BITS-1:0] pick_c;
   logic                           distinct;

   assign seen   = first ? 2'd0 : state.seen_count;
   assign parity = first ? 1'b0 : state.position_parity;
   assign slot   = first ? 2'd0 : state.list_slot;
   assign anchor = (seen == 2'd0) ? cur_index : state.anchor_index;

   assign distinct = (state.older_index != state.newer_index) &&
                     (state.newer_index != cur_index) &&
                     (state.older_index != cur_index);

   always_comb begin
      result.emit = 1'b0;
      pick_a = state.older_index;
      pick_b = cur_index;
      pick_c = state.newer_index;
      case (mode)
         tpa_pkg::MODE_LIST: begin
            result.emit = (slot == 2'd2);
         end
         tpa_pkg::MODE_STRIP: begin
            result.emit = (seen == 2'd2) && distinct;
            if (parity) begin
               pick_a = state.newer_index;
               pick_b = cur_index;
               pick_c = state.older_index;
            end else begin
               pick_a = state.older_index;
               pick_b = cur_index;
               pick_c = state.newer_index;
            end
         end
         tpa_pkg::MODE_FAN: begin
            result.emit = (seen == 2'd2);
            pick_a = anchor;
            pick_b = cur_index;
            pick_c = state.newer_index;
         end
         default: begin
            result.emit = 1'b0;
         end
      endcase
      result.corner_a = base + tpa_pkg::CORNER_BITS'(pick_a);
      result.corner_b = base + tpa_pkg::CORNER_BITS'(pick_b);
      result.corner_c = base + tpa_pkg::CORNER_BITS'(pick_c);
   end

   assign next_state.older_index     = state.newer_index;
   assign next_state.newer_index     = cur_index;
   assign next_state.anchor_index    = anchor;
   assign next_state.seen_count      = (seen == 2'd2) ? 2'd2 : seen + 2'd1;
   assign next_state.position_parity = ~parity;
   assign next_state.list_slot       = (slot == 2'd2) ? 2'd0 : slot + 2'd1;

endmodule

// File: src/tpa_checker.sv
//------------------------------------------------------------------------------
// Triangle primitive assembly checker
// Port-level assertions on the assembly block, bound to its top level.
//------------------------------------------------------------------------------
`include "triangle_primitive_assembly_macros.svh"

module tpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_corner_a,
   input logic [31:0] rsp_corner_b,
   input logic [31:0] rsp_corner_c
);

   `TPA_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)
   `TPA_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)
   `TPA_ASSERT(a_result_from_request, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready))
   `TPA_ASSERT(a_stalled_result_holds, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_corner_a) && $stable(rsp_corner_b) && $stable(rsp_corner_c)))

endmodule

bind triangle_primitive_assembly tpa_checker u_tpa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_corner_a (rsp_corner_a),
   .rsp_corner_b (rsp_corner_b),
   .rsp_corner_c (rsp_corner_c)
);
